>>> hw/rtl/sobel_pkg.sv
package sobel_pkg;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 4096;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MODE   = 2'd2;
  localparam logic [1:0] REG_THRESH = 2'd3;

  localparam logic [11:0] WIDTH_RST  = 12'd640;
  localparam logic [12:0] HEIGHT_RST = 13'd480;
  localparam logic [10:0] THRESH_RST = 11'd40;

  // one window-evaluation job handed from front to back
  typedef struct packed {
    logic [7:0]  p00, p01, p02;
    logic [7:0]  p10, p11, p12;
    logic [7:0]  p20, p21, p22;
    logic [10:0] col;
    logic [11:0] row;
    logic        last;
    logic        done;
  } job_t;

  // configuration seen by the back end
  typedef struct packed {
    logic        mode;
    logic [10:0] thresh;
  } eval_cfg_t;

endpackage

>>> hw/rtl/sobel_edge_magnitude.sv
// Channel  | Ports                                              | Direction
// input    | in_valid, in_stall, in_pixel_in                     | pixel in
// output   | out_valid, out_stall, out_edge_value..out_frame_done| result out
// config   | psel, penable, pwrite, paddr, pwdata, prdata, pready| register port
// A pixel is taken (S_TAKE), shifted into the window (S_SHIFT), and its zero to four
// window jobs are queued one per cycle (S_EMIT) before the front takes the next pixel.
// Each result passes the back end's take, square, 10 root steps and output in magnitude
// mode, with one compare for the root steps in threshold mode, and output stalls hold it;
// the back end sets the rate. rst_n is synchronous; line stores are not cleared. Input stalls while the queue
// has fewer than four free slots, that is until the queue has drained.
module sobel_edge_magnitude #(
  parameter int MAX_WIDTH  = sobel_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sobel_pkg::MAX_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_pixel_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_edge_value,
  output logic [10:0] out_out_col,
  output logic [11:0] out_out_row,
  output logic        out_last_in_run,
  output logic        out_frame_done,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [11:0] width_r;
  logic [12:0] height_r;
  logic        mode_r;
  logic [10:0] thresh_r;
  logic        wr;
  logic [1:0]  idx;
  logic        restart;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign idx = paddr[3:2];
  assign restart = wr && paddr[1:0] == 2'd0 &&
                   (idx == sobel_pkg::REG_WIDTH || idx == sobel_pkg::REG_HEIGHT);

  // register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= sobel_pkg::WIDTH_RST;
      height_r <= sobel_pkg::HEIGHT_RST;
      mode_r <= 1'b0;
      thresh_r <= sobel_pkg::THRESH_RST;
    end else if (wr && paddr[1:0] == 2'd0) begin
      case (idx)
        sobel_pkg::REG_WIDTH:  width_r <= pwdata[11:0];
        sobel_pkg::REG_HEIGHT: height_r <= pwdata[12:0];
        sobel_pkg::REG_MODE:   mode_r <= pwdata[0];
        sobel_pkg::REG_THRESH: thresh_r <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  // register read
  always_comb begin
    case (idx)
      sobel_pkg::REG_WIDTH:  prdata = {20'd0, width_r};
      sobel_pkg::REG_HEIGHT: prdata = {19'd0, height_r};
      sobel_pkg::REG_MODE:   prdata = {31'd0, mode_r};
      sobel_pkg::REG_THRESH: prdata = {21'd0, thresh_r};
      default: prdata = '0;
    endcase
  end

  logic            fjob_valid, qrd_valid, qtake;
  sobel_pkg::job_t fjob, qjob;
  logic [2:0]      qfree;
  sobel_pkg::eval_cfg_t ecfg;
  assign ecfg.mode = mode_r;
  assign ecfg.thresh = thresh_r;

  sobel_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_pixel_in,
    .width(width_r), .height(height_r), .restart,
    .job_valid(fjob_valid), .job(fjob), .q_free(qfree)
  );

  sobel_queue u_queue (
    .clk, .rst_n, .wr_en(fjob_valid), .wr_data(fjob), .free(qfree),
    .rd_valid(qrd_valid), .rd_data(qjob), .rd_en(qtake)
  );

  sobel_back u_back (
    .clk, .rst_n, .job_valid(qrd_valid), .job(qjob), .job_take(qtake), .cfg(ecfg),
    .out_valid, .out_stall, .out_edge_value, .out_out_col, .out_out_row,
    .out_last_in_run, .out_frame_done
  );

  // frame end result always closes the run of its pixel
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> out_last_in_run) else $error("done without last");
  // threshold output is binary
  a_bin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && mode_r && !out_stall |-> out_edge_value == 8'd255 || out_edge_value == 8'd0)
    else $error("non-binary threshold output");
  // input is never taken while the queue holds any job
  a_room: assert property (@(posedge clk) disable iff (!rst_n)
    qfree < 3'd4 |-> in_stall) else $error("input taken without room");

endmodule

>>> hw/rtl/sobel_front.sv
module sobel_front #(
  parameter int MAX_WIDTH  = sobel_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sobel_pkg::MAX_HEIGHT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_pixel_in,
  input  logic [11:0]       width,
  input  logic [12:0]       height,
  input  logic              restart,
  output logic              job_valid,
  output sobel_pkg::job_t   job,
  input  logic [2:0]        q_free
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  typedef enum logic [2:0] {
    S_TAKE  = 3'b001,
    S_SHIFT = 3'b010,
    S_EMIT  = 3'b100
  } fstate_t;

  logic [7:0] upper_mem [MAX_WIDTH];
  logic [7:0] middle_mem [MAX_WIDTH];

  fstate_t    state_r, state_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [7:0] win_r [9];
  logic [7:0] up_rd_r, mid_rd_r, px_r;
  logic [CW-1:0] c_r;
  logic [RW-1:0] r_r;
  logic [1:0] k_r, k_nxt;
  logic       lc_r, lr_r;

  logic [CW:0] w_eff;
  logic [RW:0] h_eff;
  logic [CW-1:0] c_cl;
  logic [RW-1:0] r_cl;
  logic take;

  // clamp frame size to the supported range
  always_comb begin
    if (width < 12'd2) w_eff = (CW+1)'(2);
    else if ({20'd0, width} > 32'(MAX_WIDTH)) w_eff = (CW+1)'(MAX_WIDTH);
    else w_eff = (CW+1)'(width);
    if (height < 13'd2) h_eff = (RW+1)'(2);
    else if ({19'd0, height} > 32'(MAX_HEIGHT)) h_eff = (RW+1)'(MAX_HEIGHT);
    else h_eff = (RW+1)'(height);
    c_cl = ({1'b0, col_r} >= w_eff) ? CW'(w_eff - 1'b1) : col_r;
    r_cl = ({1'b0, row_r} >= h_eff) ? RW'(h_eff - 1'b1) : row_r;
  end

  // accept only in the take state and when the queue can hold all four possible jobs
  assign in_stall = (state_r != S_TAKE) || (q_free < 3'd4);
  assign take = in_valid && !in_stall;

  // line stores: read old column, write new
  always_ff @(posedge clk) begin
    if (take) begin
      up_rd_r <= upper_mem[c_cl];
      mid_rd_r <= middle_mem[c_cl];
      upper_mem[c_cl] <= middle_mem[c_cl];
      middle_mem[c_cl] <= in_pixel_in;
      px_r <= in_pixel_in;
      c_r <= c_cl;
      r_r <= r_cl;
      lc_r <= ({1'b0, c_cl} == w_eff - 1'b1);
      lr_r <= ({1'b0, r_cl} == h_eff - 1'b1);
    end
  end

  logic [CW-1:0] c1;
  logic [RW-1:0] r1;
  logic emit_any;
  logic [1:0] nk;
  assign c1 = CW'(1);
  assign r1 = RW'(1);
  assign emit_any = (r_r >= r1) && (c_r >= c1);
  // index of the final job: the row-end job is skipped when not at row end
  assign nk = lr_r ? (lc_r ? 2'd3 : 2'd2) : (lc_r ? 2'd1 : 2'd0);

  // job sequencer: prev/cur selection per emission index
  logic use_rc, use_cc;
  logic [1:0] rs0, rs1, rs2, cs0, cs1, cs2;
  always_comb begin
    case (k_r)
      2'd0: begin use_rc = 1'b0; use_cc = 1'b0; end
      2'd1: begin use_rc = !lc_r; use_cc = lc_r; end
      2'd2: begin use_rc = 1'b1; use_cc = 1'b0; end
      default: begin use_rc = 1'b1; use_cc = 1'b1; end
    endcase
    rs0 = use_rc ? 2'd1 : ((r_r == r1) ? 2'd2 : 2'd0);
    rs1 = use_rc ? 2'd2 : 2'd1;
    rs2 = 2'd2;
    cs0 = use_cc ? 2'd1 : ((c_r == c1) ? 2'd2 : 2'd0);
    cs1 = use_cc ? 2'd2 : 2'd1;
    cs2 = 2'd2;
    job.p00 = win_r[rs0*3+cs0]; job.p01 = win_r[rs0*3+cs1]; job.p02 = win_r[rs0*3+cs2];
    job.p10 = win_r[rs1*3+cs0]; job.p11 = win_r[rs1*3+cs1]; job.p12 = win_r[rs1*3+cs2];
    job.p20 = win_r[rs2*3+cs0]; job.p21 = win_r[rs2*3+cs1]; job.p22 = win_r[rs2*3+cs2];
    job.col = 11'(use_cc ? c_r : c_r - 1'b1);
    job.row = 12'(use_rc ? r_r : r_r - 1'b1);
    job.last = (k_r == nk);
    job.done = (k_r == 2'd3);
  end

  assign job_valid = (state_r == S_EMIT) && emit_any;

  // advance counters and sequence state
  always_comb begin
    state_nxt = state_r;
    col_nxt = col_r;
    row_nxt = row_r;
    k_nxt = k_r;
    case (state_r)
      S_TAKE: begin
        if (take) begin
          state_nxt = S_SHIFT;
          k_nxt = 2'd0;
          if ({1'b0, c_cl} + 1'b1 >= w_eff) begin
            col_nxt = '0;
            row_nxt = ({1'b0, r_cl} + 1'b1 >= h_eff) ? '0 : r_cl + 1'b1;
          end else begin
            col_nxt = c_cl + 1'b1;
            row_nxt = r_cl;
          end
        end
      end
      S_SHIFT: state_nxt = S_EMIT;
      S_EMIT: begin
        if (!emit_any || k_r == nk) state_nxt = S_TAKE;
        else if (!lc_r && k_r == 2'd0) k_nxt = 2'd2;
        else k_nxt = k_r + 1'b1;
      end
      default: state_nxt = S_TAKE;
    endcase
    if (restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_TAKE;
      col_r <= '0;
      row_r <= '0;
      k_r <= '0;
      for (int i = 0; i < 9; i++) win_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      col_r <= col_nxt;
      row_r <= row_nxt;
      k_r <= k_nxt;
      // shift window once the line-store read has landed
      if (state_r == S_SHIFT) begin
        for (int i = 0; i < 3; i++) begin
          win_r[i*3] <= win_r[i*3+1];
          win_r[i*3+1] <= win_r[i*3+2];
        end
        win_r[2] <= up_rd_r; win_r[5] <= mid_rd_r; win_r[8] <= px_r;
      end
    end
  end

endmodule

>>> hw/rtl/sobel_queue.sv
module sobel_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  sobel_pkg::job_t wr_data,
  output logic [2:0]      free,
  output logic            rd_valid,
  output sobel_pkg::job_t rd_data,
  input  logic            rd_en
);

  sobel_pkg::job_t mem_r [8];
  logic [2:0] wp_r, rp_r;
  logic [3:0] cnt_r;

  assign rd_valid = (cnt_r != 4'd0);
  assign rd_data = mem_r[rp_r];
  assign free = (cnt_r > 4'd4) ? 3'd0 : 3'(4'd4 - cnt_r);

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  // track fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd_en) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + {3'd0, wr_en} - {3'd0, rd_en};
    end
  end

endmodule

>>> hw/rtl/sobel_back.sv
module sobel_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_valid,
  input  sobel_pkg::job_t     job,
  output logic                job_take,
  input  sobel_pkg::eval_cfg_t cfg,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_edge_value,
  output logic [10:0]         out_out_col,
  output logic [11:0]         out_out_row,
  output logic                out_last_in_run,
  output logic                out_frame_done
);

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_SQR  = 4'b0010,
    B_ROOT = 4'b0100,
    B_OUT  = 4'b1000
  } bstate_t;

  bstate_t state_r;
  logic signed [10:0] gx_r, gy_r;
  logic [20:0] n_r;
  logic [9:0] root_r;
  logic [3:0] it_r;
  logic [10:0] col_r;
  logic [11:0] row_r;
  logic last_r, done_r;
  logic [7:0] val_r;

  logic signed [10:0] gx, gy;
  assign gx = 11'(({3'd0, job.p02} + {2'd0, job.p12, 1'b0} + {3'd0, job.p22})
            - ({3'd0, job.p00} + {2'd0, job.p10, 1'b0} + {3'd0, job.p20}));
  assign gy = 11'(({3'd0, job.p20} + {2'd0, job.p21, 1'b0} + {3'd0, job.p22})
            - ({3'd0, job.p00} + {2'd0, job.p01, 1'b0} + {3'd0, job.p02}));

  assign job_take = (state_r == B_IDLE) && job_valid;
  assign out_valid = (state_r == B_OUT);
  assign out_edge_value = val_r;
  assign out_out_col = col_r;
  assign out_out_row = row_r;
  assign out_last_in_run = last_r;
  assign out_frame_done = done_r;

  // one root bit per cycle, restoring method over 10 bits
  logic [9:0] trial_bit;
  logic [20:0] trial;
  logic [9:0] root_fin;
  assign trial_bit = 10'(10'd1 << it_r);
  assign trial = 21'({root_r | trial_bit} * {root_r | trial_bit});
  assign root_fin = (trial <= n_r) ? (root_r | trial_bit) : root_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      case (state_r)
        B_IDLE: begin
          if (job_valid) begin
            gx_r <= gx; gy_r <= gy;
            col_r <= job.col; row_r <= job.row;
            last_r <= job.last; done_r <= job.done;
            state_r <= B_SQR;
          end
        end
        B_SQR: begin
          n_r <= 21'(gx_r * gx_r) + 21'(gy_r * gy_r);
          root_r <= '0;
          it_r <= 4'd9;
          state_r <= B_ROOT;
        end
        B_ROOT: begin
          if (cfg.mode) begin
            val_r <= ({1'b0, n_r} > 22'({11'd0, cfg.thresh} * {11'd0, cfg.thresh}))
                     ? 8'd255 : 8'd0;
            state_r <= B_OUT;
          end else begin
            root_r <= root_fin;
            if (it_r == 4'd0) begin
              state_r <= B_OUT;
              val_r <= (root_fin > 10'd255) ? 8'd255 : root_fin[7:0];
            end else it_r <= it_r - 1'b1;
          end
        end
        B_OUT: begin
          if (!out_stall) state_r <= B_IDLE;
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule
